@@ rtl/psu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared widths, register indexes, filter codes and the record types used
// between the top level and the predictor.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int DATA_W  = 8;
    localparam int BPL_W   = 14;
    localparam int BPP_W   = 4;
    localparam int CFG_W   = 14;
    localparam int EPOCH_W = 8;

    // Epoch zero is what a clearing pass writes, so it never matches.
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic [0:0] CFG_BYTES_PER_LINE  = 1'b0;
    localparam logic [0:0] CFG_BYTES_PER_PIXEL = 1'b1;

    localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(8);

    localparam logic [DATA_W-1:0] FILT_NONE  = 8'd0;
    localparam logic [DATA_W-1:0] FILT_SUB   = 8'd1;
    localparam logic [DATA_W-1:0] FILT_UP    = 8'd2;
    localparam logic [DATA_W-1:0] FILT_AVG   = 8'd3;
    localparam logic [DATA_W-1:0] FILT_PAETH = 8'd4;

    // One entry of the prior-line memory: the byte and the epoch it was
    // written in.
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [DATA_W-1:0]  data;
    } prior_word_t;

    // Operands of one reconstruction.
    typedef struct packed {
        logic [DATA_W-1:0] kind;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
    } pred_in_t;

endpackage

@@ rtl/psu_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/psu_predict.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline predictor
// Rebuilds one byte from the filtered byte and its left, upper and
// upper-left neighbors for the None, Sub, Up, Average and Paeth filters.
// ----------------------------------------------------------------------------
module psu_predict import psu_pkg::*; (
    input  pred_in_t          pin,
    output logic [DATA_W-1:0] recon
);

    logic [9:0]        diff_a;
    logic [9:0]        diff_b;
    logic [9:0]        diff_c;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [8:0]        pair_sum;
    logic [DATA_W-1:0] pick;

    always_comb
    begin
        // Distances of the estimate a + b - c to a, b and c.
        diff_a = {2'b00, pin.b} - {2'b00, pin.c};
        diff_b = {2'b00, pin.a} - {2'b00, pin.c};
        diff_c = {2'b00, pin.a} + {2'b00, pin.b} - {1'b0, pin.c, 1'b0};
        pa = diff_a[9] ? (~diff_a + 10'd1) : diff_a;
        pb = diff_b[9] ? (~diff_b + 10'd1) : diff_b;
        pc = diff_c[9] ? (~diff_c + 10'd1) : diff_c;

        priority if (pa <= pb && pa <= pc)
        begin
            pick = pin.a;
        end
        else if (pb <= pc)
        begin
            pick = pin.b;
        end
        else
        begin
            pick = pin.c;
        end

        pair_sum = {1'b0, pin.a} + {1'b0, pin.b};

        unique case (pin.kind)
            FILT_NONE:  recon = pin.x;
            FILT_SUB:   recon = pin.x + pin.a;
            FILT_UP:    recon = pin.x + pin.b;
            FILT_AVG:   recon = pin.x + pair_sum[8:1];
            FILT_PAETH: recon = pin.x + pick;
            // Unknown filter types pass the byte through.
            default:    recon = pin.x;
        endcase
    end

endmodule

@@ rtl/png_scanline_unfilter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs the raw image bytes of a filtered, inflated PNG stream,
// one byte per beat, keeping the prior scanline in a block RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  -------   ---  ---------          -------
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tuser[0] start_image
//  m_*       out  m_tvalid/m_tready  m_tdata[7:0] recon_byte, m_tlast line_end
//  cfg_*     in   cfg_we             cfg_index 0 bytes_per_line, 1 bytes_per_pixel
//
//  Throughput is one byte per cycle while s_tready is high. A data byte is
//  accepted, its prior-line entry is read from the RAM on the next cycle,
//  and the rebuilt byte is written back and queued for output. The filter
//  byte that opens a line yields no output. After reset the RAM is swept
//  once to clear it, with s_tready low. A start_image beat clears the
//  prior line by advancing an epoch tag kept with each RAM entry; the tag
//  runs from 1 to 255, and a start_image beat arriving at the last tag
//  value first waits for a new sweep.
//  Output stalls are absorbed by a four-entry output queue; outside the
//  sweeps, s_tready drops only when the queue plus the byte in flight
//  could not take another one.
//
module png_scanline_unfilter import psu_pkg::*; #(
    parameter int MAX_LINE_BYTES = 8192
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] data_byte
    input  logic [0:0]       s_tuser,    // [0] start_image
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,    // [7:0] recon_byte
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int COL_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int POS_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int LEN_W = (POS_W > BPL_W) ? POS_W : BPL_W;
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_LINE_BYTES);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_LINE_BYTES - 1);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    // Room check: queued beats plus the byte in flight must leave space for
    // the byte accepted now.
    localparam logic [CNT_W-1:0] FIFO_ROOM = CNT_W'(FIFO_DEPTH - 1);

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    // A data byte between acceptance and write-back.
    typedef struct packed {
        logic [COL_W-1:0]  addr;
        logic [2:0]        col_lo;
        logic [2:0]        hist_idx;
        logic              has_left;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] kind;
        logic              last;
    } stage_t;

    typedef struct packed {
        logic              last;
        logic [DATA_W-1:0] recon;
    } out_beat_t;

    // Control and configuration state.
    logic               state_reg,    state_next;
    logic [COL_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg,    epoch_next;
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [DATA_W-1:0]  filter_reg,   filter_next;
    logic [BPL_W-1:0]   bpl_reg;
    logic [BPP_W-1:0]   bpp_reg;

    // Second stage: RAM data arrives, byte is rebuilt and written back.
    logic               p1_valid_reg, p1_valid_next;
    stage_t             p1_reg,       p1_next;
    logic               fwd_hit_reg;
    prior_word_t        fwd_word_reg;

    // Recent rebuilt bytes and the bytes above them, indexed by column mod 8.
    logic [DATA_W-1:0]  left_reg  [8];
    logic [DATA_W-1:0]  upper_reg [8];

    // Output queue.
    out_beat_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // First-stage decode.
    logic               accept;
    logic               is_filter;
    logic               wrap_pend;
    logic [LEN_W-1:0]   len_eff;
    logic [BPP_W-1:0]   pix_dist;
    logic [LEN_W-1:0]   col_ext;
    logic               line_last;
    logic [COL_W-1:0]   rd_addr;

    // RAM port and second-stage datapath.
    logic               ram_we;
    logic [COL_W-1:0]   ram_waddr;
    prior_word_t        ram_wdata;
    prior_word_t        ram_rdata;
    prior_word_t        rd_word;
    logic [DATA_W-1:0]  above;
    pred_in_t           pin;
    logic [DATA_W-1:0]  recon;
    logic               push;
    logic               pop;

    // ------------------------------------------------------------------
    // First stage: position in the line, clamps and RAM read address.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (bpl_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(bpl_reg) > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = LEN_W'(bpl_reg);
        end

        if (bpp_reg == '0)
        begin
            pix_dist = BPP_W'(1);
        end
        else if (bpp_reg > BPP_MAX)
        begin
            pix_dist = BPP_MAX;
        end
        else
        begin
            pix_dist = bpp_reg;
        end

        // Column of a data byte; position zero is the filter byte.
        col_ext = LEN_W'(pos_reg) - LEN_W'(1);
        if (col_ext > LEN_W'(COL_LAST))
        begin
            col_ext = LEN_W'(COL_LAST);
        end

        // A shortened line ends at the first byte at or past its new end.
        line_last = (col_ext + LEN_W'(1)) >= len_eff;
        rd_addr   = col_ext[COL_W-1:0];
    end

    assign is_filter = (pos_reg == '0);
    assign wrap_pend = s_tvalid && s_tuser[0] && (epoch_reg == EPOCH_LAST);
    assign s_tready  = (state_reg == ST_RUN) && !wrap_pend
                     && ((cnt_reg + CNT_W'(p1_valid_reg)) <= FIFO_ROOM);
    assign accept    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Prior-line memory. The sweep owns the write port while it runs.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = p1_valid_reg;
            ram_waddr = p1_reg.addr;
            ram_wdata = '{tag: epoch_reg, data: recon};
        end
    end

    psu_ram #(
        .WIDTH ($bits(prior_word_t)),
        .DEPTH (MAX_LINE_BYTES)
    ) u_prior_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Second stage. A write to the entry being read in the same cycle is
    // forwarded; an entry tagged with an older epoch reads as zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        rd_word = fwd_hit_reg ? fwd_word_reg : ram_rdata;
        above   = (rd_word.tag == epoch_reg) ? rd_word.data : '0;

        pin.kind = p1_reg.kind;
        pin.x    = p1_reg.x;
        pin.b    = above;
        pin.a    = p1_reg.has_left ? left_reg[p1_reg.hist_idx]  : '0;
        pin.c    = p1_reg.has_left ? upper_reg[p1_reg.hist_idx] : '0;
    end

    psu_predict u_predict (
        .pin   (pin),
        .recon (recon)
    );

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    assign push = p1_valid_reg;
    assign pop  = m_tvalid && m_tready;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        pos_next      = pos_reg;
        filter_next   = filter_reg;
        p1_valid_next = 1'b0;

        p1_next.addr     = rd_addr;
        p1_next.col_lo   = col_ext[2:0];
        p1_next.hist_idx = col_ext[2:0] - pix_dist[2:0];
        p1_next.has_left = col_ext >= LEN_W'(pix_dist);
        p1_next.x        = s_tdata;
        p1_next.kind     = filter_reg;
        p1_next.last     = line_last;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_LAST)
                begin
                    state_next = ST_RUN;
                    epoch_next = EPOCH_FIRST;
                end
            end
            ST_RUN:
            begin
                // Tags are about to run out: sweep once the write port is free.
                if (wrap_pend && !p1_valid_reg)
                begin
                    state_next    = ST_CLEAR;
                    clr_addr_next = '0;
                end
                if (accept)
                begin
                    if (s_tuser[0])
                    begin
                        epoch_next = epoch_reg + EPOCH_W'(1);
                    end
                    if (is_filter)
                    begin
                        filter_next = s_tdata;
                        pos_next    = POS_W'(1);
                    end
                    else
                    begin
                        p1_valid_next = 1'b1;
                        pos_next      = line_last ? '0 : pos_reg + POS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            epoch_reg    <= EPOCH_FIRST;
            pos_reg      <= '0;
            filter_reg   <= '0;
            bpl_reg      <= BPL_W'(1);
            bpp_reg      <= BPP_W'(1);
            p1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                left_reg[i]  <= '0;
                upper_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            epoch_reg    <= epoch_next;
            pos_reg      <= pos_next;
            filter_reg   <= filter_next;
            p1_valid_reg <= p1_valid_next;
            fwd_hit_reg  <= ram_we && (ram_waddr == rd_addr);
            cnt_reg      <= cnt_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BYTES_PER_LINE:  bpl_reg <= cfg_data[BPL_W-1:0];
                    CFG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                    default:             bpl_reg <= bpl_reg;
                endcase
            end

            if (p1_valid_reg)
            begin
                left_reg[p1_reg.col_lo]  <= recon;
                upper_reg[p1_reg.col_lo] <= above;
            end

            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        p1_reg       <= p1_next;
        fwd_word_reg <= ram_wdata;
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{last: p1_reg.last, recon: recon};
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = fifo_reg[rd_ptr_reg].recon;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

endmodule

@@ rtl/psu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter port checker
// Watches the stream ports of the top level over time and is bound to it.
// ----------------------------------------------------------------------------
module psu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat withdrawn while stalled");

    // A stalled output beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // An empty output side only fills from an earlier accepted input beat.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without a matching input beat");

    // The memory sweep after reset holds off the input side.
    a_reset_sweep: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !s_tready)
        else $error("input accepted before the prior-line sweep");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filtered scanlines into the unfilter block and checks every
// reconstructed beat against a behavioral predictor kept in step with the
// stream. Directed lines cover each filter type, unknown filter codes and a
// line length lowered in the middle of a line. Random lines follow, then a
// run of image restarts long enough to wrap the clearing tag, and a line
// started at the greatest length.
// ----------------------------------------------------------------------------
module tb;
    import psu_pkg::*;

    localparam int LINE_MAX    = 8192;
    // The block may hold s_tready low for a full RAM sweep after reset and on
    // a tag wrap. Allow several sweeps plus the longest idle gaps.
    localparam int STALL_LIMIT = 40000;

    // One reconstructed byte as it should leave the block.
    typedef struct packed {
        logic [7:0] recon;
        logic       line_end;
    } recon_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;    // [7:0] data_byte
    logic [0:0]       s_tuser;    // [0] start_image
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;    // [7:0] recon_byte
    logic             m_tlast;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    png_scanline_unfilter #(
        .MAX_LINE_BYTES (LINE_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a private copy of the line memory, the two history
    // rings, the position in the line and the raw register values.
    logic [7:0]     line_above [LINE_MAX];
    logic [7:0]     left_ring  [8];
    logic [7:0]     diag_ring  [8];
    int unsigned    line_pos;
    logic [7:0]     cur_filter;
    logic [13:0]    len_reg;
    logic [3:0]     dist_reg;

    // Reconstructed bytes predicted but not yet seen on the master side.
    recon_t         pending_recon [$];

    int             mismatches;
    int             beats_sent;
    // When set, both sides run back to back without idle cycles.
    bit             calm;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned gap_of(input int unsigned x, input int unsigned y);
        return (x > y) ? x - y : y - x;
    endfunction

    // Paeth predictor: pick whichever neighbor is closest to left + up - diag,
    // with ties going to left, then up.
    function automatic int unsigned paeth_choose(input int unsigned a, input int unsigned b,
                                                 input int unsigned c);
        int unsigned pa;
        int unsigned pb;
        int unsigned pc;
        pa = gap_of(b, c);
        pb = gap_of(a, c);
        pc = gap_of(a + b, c + c);
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic clear_line_above();
        foreach (line_above[i])
            line_above[i] = 8'h00;
    endtask

    // Advance the predictor by one accepted input beat and queue the byte it
    // should produce, if any.
    task automatic predict_recon(input logic [7:0] value, input logic restart);
        int unsigned len;
        int unsigned pix_dist;
        int unsigned col;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned r;
        logic        last;
        if (restart)
            clear_line_above();
        if (line_pos == 0)
        begin
            // The filter byte opens the line and produces nothing.
            cur_filter = value;
            line_pos = 1;
            return;
        end
        len = len_reg;
        if (len < 1)
            len = 1;
        if (len > LINE_MAX)
            len = LINE_MAX;
        pix_dist = dist_reg;
        if (pix_dist < 1)
            pix_dist = 1;
        if (pix_dist > 8)
            pix_dist = 8;
        col = line_pos - 1;
        if (col >= LINE_MAX)
            col = LINE_MAX - 1;
        a = 0;
        c = 0;
        b = line_above[col];
        // Near the line start there is no left neighbor yet.
        if (col >= pix_dist)
        begin
            a = left_ring[(col - pix_dist) % 8];
            c = diag_ring[(col - pix_dist) % 8];
        end
        case (cur_filter)
            FILT_SUB:   r = value + a;
            FILT_UP:    r = value + b;
            FILT_AVG:   r = value + ((a + b) >> 1);
            FILT_PAETH: r = value + paeth_choose(a, b, c);
            default:    r = value;
        endcase
        r = r & 32'hFF;
        diag_ring[col % 8] = b[7:0];
        left_ring[col % 8] = r[7:0];
        line_above[col] = r[7:0];
        // A length lowered mid-line ends the line at the current byte.
        last = (col + 1 >= len);
        line_pos = last ? 0 : line_pos + 1;
        pending_recon.push_back('{recon: r[7:0], line_end: last});
    endtask

    // Offer one input beat after a random idle gap and wait for it to be
    // taken. Returns at the following falling edge with s_tvalid still high,
    // so a back-to-back beat can follow without lowering it.
    task automatic push_byte(input logic [7:0] value, input logic restart);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        predict_recon(value, restart);
        beats_sent++;
        @(negedge clk);
    endtask

    // Stop offering input, let every predicted byte come out, let the
    // pipeline idle for a trailing filter byte, and wait out any
    // RAM sweep. Returns at a falling edge.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_recon.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register write; only called after settle_block or another register write.
    task automatic write_reg(input logic [0:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == CFG_BYTES_PER_LINE)
            len_reg = value[13:0];
        else
            dist_reg = value[3:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Every filter type once, plus two unknown codes, on two-byte lines with
    // data at the extremes. The Up line restarts the image on its filter
    // byte, so it sees a cleared line above.
    task automatic test_filter_types();
        logic [7:0] kinds [7];
        logic [7:0] first [7];
        logic [7:0] second [7];
        kinds  = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH, 8'd5, 8'hFF};
        first  = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h10, 8'hAA, 8'h00};
        second = '{8'hFF, 8'h01, 8'h7F, 8'hFF, 8'hF0, 8'h55, 8'hFF};
        settle_block();
        write_reg(CFG_BYTES_PER_LINE, CFG_W'(2));
        write_reg(CFG_BYTES_PER_PIXEL, CFG_W'(1));
        for (int i = 0; i < 7; i++)
        begin
            push_byte(kinds[i], kinds[i] == FILT_UP);
            push_byte(first[i], 1'b0);
            push_byte(second[i], 1'b0);
        end
    endtask

    // Start a six-byte line, pause, then shrink the line to one byte: the
    // very next byte must end the line.
    task automatic test_length_lowered();
        settle_block();
        write_reg(CFG_BYTES_PER_LINE, CFG_W'(6));
        push_byte(FILT_SUB, 1'b0);
        push_byte(8'h21, 1'b0);
        push_byte(8'h43, 1'b0);
        settle_block();
        write_reg(CFG_BYTES_PER_LINE, CFG_W'(1));
        push_byte(8'h65, 1'b0);
    endtask

    // Random phases of well-formed lines with random content. Each phase
    // picks new register values, extremes included, and a phase may stop in
    // the middle of a line so that the next setting applies mid-line.
    task automatic test_random_lines(input int budget);
        int          stop_at;
        int unsigned lines;
        int unsigned eff_len;
        int unsigned cut;
        int unsigned sent_in_line;
        logic [CFG_W-1:0] len_val;
        logic [CFG_W-1:0] dist_val;
        logic [7:0]  kind;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at)
        begin
            settle_block();
            case ($urandom_range(0, 9))
                0:       len_val = CFG_W'(0);
                1:       len_val = CFG_W'(1);
                2:       len_val = CFG_W'(2);
                3:       len_val = '1;
                4:       len_val = CFG_W'(LINE_MAX);
                default: len_val = CFG_W'($urandom_range(3, 24));
            endcase
            case ($urandom_range(0, 9))
                0:       dist_val = CFG_W'(0);
                1:       dist_val = CFG_W'(1);
                2:       dist_val = CFG_W'(8);
                3:       dist_val = CFG_W'(15);
                4:       dist_val = CFG_W'(9);
                default: dist_val = CFG_W'($urandom_range(1, 8));
            endcase
            // Random upper bits in the pixel distance write are ignored by
            // the block except for the low four.
            if ($urandom_range(0, 3) == 0)
                dist_val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            write_reg(CFG_BYTES_PER_LINE, len_val);
            write_reg(CFG_BYTES_PER_PIXEL, dist_val);
            calm = ($urandom_range(0, 3) == 0);
            eff_len = (len_reg == 0) ? 1 : (len_reg > LINE_MAX ? LINE_MAX : len_reg);
            lines = $urandom_range(1, 6);
            for (int n = 0; n < lines && beats_sent < stop_at; n++)
            begin
                // Long lines are always cut short to keep the run small.
                if (eff_len > 64)
                    cut = $urandom_range(1, 48);
                else if ($urandom_range(0, 3) == 0)
                    cut = $urandom_range(1, eff_len);
                else
                    cut = eff_len + 1;
                if (line_pos == 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                        kind = 8'($urandom_range(0, 255));
                    else
                        kind = 8'($urandom_range(0, 4));
                    push_byte(kind, $urandom_range(0, 7) == 0);
                end
                sent_in_line = 0;
                while (line_pos != 0 && sent_in_line < cut)
                begin
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
                    sent_in_line++;
                end
            end
        end
        calm = 1'b0;
    endtask

    // Enough image restarts in a row to run the clearing tag past its last
    // value, which forces a second RAM sweep while beats are waiting.
    task automatic test_image_restarts();
        settle_block();
        write_reg(CFG_BYTES_PER_LINE, CFG_W'(3));
        write_reg(CFG_BYTES_PER_PIXEL, CFG_W'(1));
        for (int i = 0; i < 300; i++)
        begin
            if (line_pos == 0)
                push_byte(8'($urandom_range(0, 4)), 1'b1);
            else
                push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // A Sub line started at the greatest length and then shortened so that
    // the next byte ends it, followed by a Paeth line of that length which
    // reads every stored byte back.
    task automatic test_widest_setting();
        settle_block();
        // Close any line left open by the random phase.
        if (line_pos != 0)
        begin
            write_reg(CFG_BYTES_PER_LINE, CFG_W'(1));
            push_byte(8'($urandom_range(0, 255)), 1'b0);
            settle_block();
        end
        write_reg(CFG_BYTES_PER_LINE, CFG_W'(LINE_MAX));
        write_reg(CFG_BYTES_PER_PIXEL, CFG_W'(3));
        calm = 1'b1;
        push_byte(FILT_SUB, 1'b0);
        for (int i = 0; i < 40; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        settle_block();
        write_reg(CFG_BYTES_PER_LINE, CFG_W'(41));
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(FILT_PAETH, 1'b0);
        while (line_pos != 0)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        calm = 1'b0;
    endtask

    // Result side: a random stall before each beat, then wait for it.
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare each output beat with the oldest prediction.
    always @(posedge clk)
    begin
        recon_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_recon.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: recon %02h last %0b", m_tdata, m_tlast);
            end
            else
            begin
                want = pending_recon.pop_front();
                if (m_tdata !== want.recon || m_tlast !== want.line_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected recon %02h last %0b, got recon %02h last %0b",
                                 want.recon, want.line_end, m_tdata, m_tlast);
                end
            end
        end
    end

    // Watchdog: give up when no beat moves on either side for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_BYTES_PER_LINE;
        cfg_data   = '0;
        rst_n      = 1'b0;
        mismatches = 0;
        beats_sent = 0;
        calm       = 1'b0;

        // Predictor state after reset.
        clear_line_above();
        foreach (left_ring[i])
        begin
            left_ring[i] = 8'h00;
            diag_ring[i] = 8'h00;
        end
        line_pos   = 0;
        cur_filter = FILT_NONE;
        len_reg    = 14'd1;
        dist_reg   = 4'd1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_filter_types();
        test_length_lowered();
        test_random_lines(500);
        test_image_restarts();
        test_random_lines(100);
        test_widest_setting();

        // Drain, then watch a little longer for stray output beats.
        s_tvalid <= 1'b0;
        while (pending_recon.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_recon.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
